### rtl/core/stg_pkg.sv
package stg_pkg;

    localparam int NUM_AXES = 3;
    localparam int TICKS_PER_MS_DEFAULT = 100;
    localparam logic [31:0] DELAY_UNIT = 32'h0001_0000;

    localparam logic [2:0] CMD_NONE     = 3'd0;
    localparam logic [2:0] CMD_MOTOR    = 3'd1;
    localparam logic [2:0] CMD_ENGRAVER = 3'd2;
    localparam logic [2:0] CMD_SERVO    = 3'd3;
    localparam logic [2:0] CMD_DELAY    = 3'd4;

    typedef struct packed {
        logic [2:0]         command;
        logic [31:0]        steps_a;
        logic [31:0]        steps_b;
        logic [31:0]        steps_c;
        logic [31:0]        rate_a;
        logic [31:0]        rate_b;
        logic [31:0]        rate_c;
        logic signed [31:0] accel_a;
        logic signed [31:0] accel_b;
        logic signed [31:0] accel_c;
        logic [2:0]         direction;
        logic [31:0]        delay_ticks;
    } tick_item_t;

    typedef struct packed {
        logic [2:0]         step_pulses;
        logic [2:0]         dir_levels;
        logic               dir_update;
        logic               command_taken;
        logic               busy_res;
        logic signed [31:0] position_a;
        logic signed [31:0] position_b;
        logic signed [31:0] position_c;
    } result_item_t;

    typedef struct packed {
        logic [31:0]        steps;
        logic [31:0]        rate;
        logic signed [31:0] accel;
        logic [30:0]        phase;
        logic signed [31:0] position;
    } axis_state_t;

    typedef struct packed {
        logic enable;
        logic dir_down;
    } axis_ctrl_t;

endpackage

### rtl/core/stg_tick_if.sv
interface stg_tick_if;
    logic                valid;
    logic                ready;
    stg_pkg::tick_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/core/stg_result_if.sv
interface stg_result_if;
    logic                  valid;
    logic                  ready;
    stg_pkg::result_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/core/three_axis_step_generator_core.sv
// result: a result item is valid in the cycle after its tick item is accepted
// throughput: one tick item per cycle unless a held result stalls it; the three
// axis lanes and the delay counter update together on each accepted item, and
// the result register lets a new item enter while the previous result is being taken
// reset: asynchronous, clears all move state, positions and result valid
module three_axis_step_generator_core #(
    parameter int TICKS_PER_MS = stg_pkg::TICKS_PER_MS_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    stg_tick_if.sink       tick,
    stg_result_if.source   result
);

    localparam logic [31:0] DELAY_LIMIT = 32'(TICKS_PER_MS * 32'h0001_0000);

    logic [2:0]                  active_cmd_reg, active_cmd_next;
    logic [2:0]                  dir_bits_reg, dir_bits_next;
    logic [31:0]                 delay_left_reg, delay_left_next;
    stg_pkg::axis_state_t        axis_reg [stg_pkg::NUM_AXES];
    stg_pkg::axis_state_t        axis_cur [stg_pkg::NUM_AXES];
    stg_pkg::axis_state_t        axis_next [stg_pkg::NUM_AXES];
    stg_pkg::axis_ctrl_t         axis_ctrl [stg_pkg::NUM_AXES];
    logic [stg_pkg::NUM_AXES-1:0] pulses;
    logic                        out_valid_reg;
    stg_pkg::result_item_t       res_reg, res_next;
    logic                        accept;
    logic                        take_cmd;
    logic [2:0]                  cmd_eff;
    logic [31:0]                 delay_cur;
    logic                        any_steps;
    logic                        done;

    assign tick.ready   = !out_valid_reg || result.ready;
    assign accept       = tick.valid && tick.ready;
    assign result.valid = out_valid_reg;
    assign result.data  = res_reg;

    // latch operands of a newly taken command
    always_comb
    begin
        take_cmd = (active_cmd_reg == stg_pkg::CMD_NONE) && (tick.data.command != stg_pkg::CMD_NONE);
        cmd_eff  = take_cmd ? tick.data.command : active_cmd_reg;
        for (int i = 0; i < stg_pkg::NUM_AXES; i++)
        begin
            axis_cur[i] = axis_reg[i];
        end
        dir_bits_next = dir_bits_reg;
        delay_cur     = delay_left_reg;
        if (take_cmd)
        begin
            axis_cur[0].steps = tick.data.steps_a;
            axis_cur[1].steps = tick.data.steps_b;
            axis_cur[2].steps = tick.data.steps_c;
            axis_cur[0].rate  = tick.data.rate_a;
            axis_cur[1].rate  = tick.data.rate_b;
            axis_cur[2].rate  = tick.data.rate_c;
            axis_cur[0].accel = tick.data.accel_a;
            axis_cur[1].accel = tick.data.accel_b;
            axis_cur[2].accel = tick.data.accel_c;
            dir_bits_next     = tick.data.direction;
            delay_cur         = tick.data.delay_ticks;
        end
        any_steps = (axis_cur[0].steps != 32'd0) || (axis_cur[1].steps != 32'd0)
                    || (axis_cur[2].steps != 32'd0);
        for (int i = 0; i < stg_pkg::NUM_AXES; i++)
        begin
            axis_ctrl[i].enable   = (cmd_eff == stg_pkg::CMD_MOTOR);
            axis_ctrl[i].dir_down = dir_bits_next[i];
        end
    end

    for (genvar g = 0; g < stg_pkg::NUM_AXES; g++)
    begin : g_lane
        stg_axis_lane u_lane (
            .cur   (axis_cur[g]),
            .ctrl  (axis_ctrl[g]),
            .nxt   (axis_next[g]),
            .pulse (pulses[g])
        );
    end

    always_comb
    begin
        delay_left_next = delay_cur;
        done            = 1'b1;
        if (cmd_eff == stg_pkg::CMD_MOTOR)
        begin
            done = !any_steps;
        end
        if ((cmd_eff == stg_pkg::CMD_DELAY) || (cmd_eff == stg_pkg::CMD_SERVO))
        begin
            if (delay_cur != 32'd0)
            begin
                // oversized delay is cut to zero
                if (delay_cur > DELAY_LIMIT)
                    delay_left_next = 32'd0;
                else
                    delay_left_next = delay_cur - 32'd1;
            end
            done = (delay_left_next == 32'd0);
        end
        active_cmd_next = done ? stg_pkg::CMD_NONE : cmd_eff;

        res_next.step_pulses   = pulses;
        res_next.dir_update    = (cmd_eff == stg_pkg::CMD_MOTOR) && any_steps;
        res_next.dir_levels    = res_next.dir_update ? dir_bits_next : 3'd0;
        res_next.command_taken = take_cmd;
        res_next.busy_res      = (active_cmd_next != stg_pkg::CMD_NONE);
        res_next.position_a    = axis_next[0].position;
        res_next.position_b    = axis_next[1].position;
        res_next.position_c    = axis_next[2].position;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_cmd_reg <= stg_pkg::CMD_NONE;
            dir_bits_reg   <= 3'd0;
            delay_left_reg <= 32'd0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < stg_pkg::NUM_AXES; i++)
            begin
                axis_reg[i] <= '0;
            end
        end
        else
        begin
            if (accept)
            begin
                active_cmd_reg <= active_cmd_next;
                dir_bits_reg   <= dir_bits_next;
                delay_left_reg <= delay_left_next;
                for (int i = 0; i < stg_pkg::NUM_AXES; i++)
                begin
                    axis_reg[i] <= axis_next[i];
                end
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("no result after accepted item");

    a_busy_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (res_reg.busy_res == (active_cmd_reg != stg_pkg::CMD_NONE)))
        else $error("busy flag disagrees with active command");

    a_take_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (active_cmd_reg != stg_pkg::CMD_NONE)) |=> !res_reg.command_taken)
        else $error("command taken while another is active");

    a_pulse_needs_dir: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (res_reg.step_pulses != 3'd0)) |-> res_reg.dir_update)
        else $error("step pulse without direction update");

    a_dir_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res_reg.dir_update) |-> (res_reg.dir_levels == 3'd0))
        else $error("direction levels driven without update");

endmodule

### rtl/core/stg_axis_lane.sv
module stg_axis_lane (
    input  stg_pkg::axis_state_t cur,
    input  stg_pkg::axis_ctrl_t  ctrl,
    output stg_pkg::axis_state_t nxt,
    output logic                 pulse
);

    logic [31:0] sum;

    always_comb
    begin
        nxt   = cur;
        pulse = 1'b0;
        sum   = {1'b0, cur.phase} + cur.rate;
        if (ctrl.enable && (cur.steps != 32'd0))
        begin
            nxt.phase = sum[30:0];
            nxt.rate  = cur.rate + $unsigned(cur.accel);
            if (sum[31])
            begin
                pulse     = 1'b1;
                nxt.steps = cur.steps - 32'd1;
                if (ctrl.dir_down)
                    nxt.position = cur.position - 32'sd1;
                else
                    nxt.position = cur.position + 32'sd1;
            end
        end
    end

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps

import stg_pkg::*;

class stepper_scoreboard;
    logic [2:0]         motion_cmd = CMD_NONE;
    logic [31:0]        remaining [NUM_AXES] = '{default: '0};
    logic [31:0]        addend [NUM_AXES] = '{default: '0};
    logic [31:0]        addend_step [NUM_AXES] = '{default: '0};
    logic [30:0]        phase [NUM_AXES] = '{default: '0};
    logic signed [31:0] position [NUM_AXES] = '{default: '0};
    logic [2:0]         dir_mask = '0;
    logic [31:0]        ticks_left = '0;
    longint unsigned    delay_ceiling = longint'(TICKS_PER_MS_DEFAULT) * DELAY_UNIT;
    result_item_t       expected_tick_results [$];
    int                 errors = 0;

    function bit busy();
        return motion_cmd != CMD_NONE;
    endfunction

    function int pending();
        return expected_tick_results.size();
    endfunction

    function void note_tick(input tick_item_t t, output bit taken);
        result_item_t r;
        logic [31:0]  sum;
        bit           done;
        r = '0;
        done = 1'b1;
        taken = 1'b0;
        if (motion_cmd == CMD_NONE && t.command != CMD_NONE)
        begin
            taken = 1'b1;
            motion_cmd = t.command;
            remaining[0] = t.steps_a;
            remaining[1] = t.steps_b;
            remaining[2] = t.steps_c;
            addend[0] = t.rate_a;
            addend[1] = t.rate_b;
            addend[2] = t.rate_c;
            addend_step[0] = t.accel_a;
            addend_step[1] = t.accel_b;
            addend_step[2] = t.accel_c;
            dir_mask = t.direction;
            ticks_left = t.delay_ticks;
        end
        if (motion_cmd != CMD_NONE)
        begin
            if (motion_cmd == CMD_MOTOR && (remaining[0] | remaining[1] | remaining[2]) != '0)
            begin
                r.dir_update = 1'b1;
                r.dir_levels = dir_mask;
                for (int i = 0; i < NUM_AXES; i++)
                begin
                    if (remaining[i] != '0)
                    begin
                        sum = {1'b0, phase[i]} + addend[i];
                        if (sum[31])
                        begin
                            r.step_pulses[i] = 1'b1;
                            remaining[i] = remaining[i] - 1;
                            if (dir_mask[i])
                                position[i] = position[i] - 1;
                            else
                                position[i] = position[i] + 1;
                        end
                        phase[i] = sum[30:0];
                        addend[i] = addend[i] + addend_step[i];
                        done = 1'b0;
                    end
                end
            end
            if (motion_cmd == CMD_DELAY || motion_cmd == CMD_SERVO)
            begin
                if (ticks_left != '0)
                begin
                    // oversized counts are dropped rather than clamped
                    if (longint'(ticks_left) > delay_ceiling)
                        ticks_left = '0;
                    else
                        ticks_left = ticks_left - 1;
                end
                if (ticks_left != '0)
                    done = 1'b0;
            end
            if (done)
                motion_cmd = CMD_NONE;
        end
        r.command_taken = taken;
        r.busy_res = (motion_cmd != CMD_NONE);
        r.position_a = position[0];
        r.position_b = position[1];
        r.position_c = position[2];
        expected_tick_results.push_back(r);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, actual %0h", field, want, got);
            errors++;
        end
    endfunction

    function void check_result(result_item_t got);
        result_item_t want;
        if (expected_tick_results.size() == 0)
        begin
            $error("result item arrived with no tick outstanding");
            errors++;
            return;
        end
        want = expected_tick_results.pop_front();
        compare_field("step_pulses", want.step_pulses, got.step_pulses);
        compare_field("dir_levels", want.dir_levels, got.dir_levels);
        compare_field("dir_update", want.dir_update, got.dir_update);
        compare_field("command_taken", want.command_taken, got.command_taken);
        compare_field("busy_res", want.busy_res, got.busy_res);
        compare_field("position_a", want.position_a, got.position_a);
        compare_field("position_b", want.position_b, got.position_b);
        compare_field("position_c", want.position_c, got.position_c);
    endfunction
endclass

module tb_top;
    localparam logic [2:0]  CMD_MAX = 3'd7;
    localparam logic [31:0] DELAY_MAX_TICKS = TICKS_PER_MS_DEFAULT * DELAY_UNIT;
    localparam int          RANDOM_TICKS = 580;
    localparam int          LONG_HOLD = 150;
    localparam int          TAIL_TICKS = 40;
    localparam int          CYCLE_LIMIT = 100000;

    logic clk = 1'b0;
    logic rst_n;

    stg_tick_if   tick_bus ();
    stg_result_if result_bus ();

    three_axis_step_generator_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick_bus),
        .result (result_bus)
    );

    stepper_scoreboard sb = new;

    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int hold_req = 0;
    int hold_ack = 0;
    int hold_left = 0;
    int cycle_count = 0;

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (result_bus.valid && result_bus.ready)
            sb.check_result(result_bus.data);
    end

    // receiver: random stalls plus one long hold-off
    initial
    begin
        result_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_ack != hold_req)
            begin
                hold_ack = hold_req;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_bus.ready <= 1'b0;
            end
            else
                result_bus.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    function automatic tick_item_t random_fields();
        tick_item_t f;
        f.command = 3'($urandom_range(0, CMD_MAX));
        f.steps_a = $urandom();
        f.steps_b = $urandom();
        f.steps_c = $urandom();
        f.rate_a = $urandom();
        f.rate_b = $urandom();
        f.rate_c = $urandom();
        f.accel_a = $urandom();
        f.accel_b = $urandom();
        f.accel_c = $urandom();
        f.direction = 3'($urandom_range(0, 7));
        f.delay_ticks = $urandom();
        return f;
    endfunction

    function automatic void plan_axis(output logic [31:0] steps, output logic [31:0] rate,
                                      output logic signed [31:0] accel, input bit wild);
        steps = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom_range(1, wild ? 3 : 6);
        if (wild)
        begin
            // large addend change keeps the rate from lingering near zero
            rate = $urandom();
            accel = $urandom();
            accel[29] = ~accel[31];
        end
        else
        begin
            rate = $urandom_range(32'h2000_0000, 32'hE000_0000);
            accel = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        end
    endfunction

    function automatic tick_item_t random_command();
        tick_item_t c;
        int         pick;
        bit         wild;
        c = random_fields();
        pick = $urandom_range(0, 99);
        wild = ($urandom_range(0, 3) == 0);
        if (pick < 60 || pick >= 96)
        begin
            c.command = CMD_MOTOR;
            plan_axis(c.steps_a, c.rate_a, c.accel_a, wild);
            plan_axis(c.steps_b, c.rate_b, c.accel_b, wild);
            plan_axis(c.steps_c, c.rate_c, c.accel_c, wild);
            if (pick >= 96)
            begin
                c.steps_a = '0;
                c.steps_b = '0;
                c.steps_c = '0;
            end
        end
        else if (pick < 80)
        begin
            c.command = (pick < 70) ? CMD_DELAY : CMD_SERVO;
            if ($urandom_range(0, 3) == 0)
                c.delay_ticks = $urandom_range(DELAY_MAX_TICKS + 1, 32'hFFFF_FFFF);
            else
                c.delay_ticks = $urandom_range(0, 24);
        end
        else if (pick < 88)
            c.command = CMD_ENGRAVER;
        else
            c.command = 3'($urandom_range(CMD_DELAY + 1, CMD_MAX));
        return c;
    endfunction

    task automatic offer_tick(input tick_item_t item, output bit taken);
        @(negedge clk);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            tick_bus.valid <= 1'b0;
            @(negedge clk);
        end
        tick_bus.valid <= 1'b1;
        tick_bus.data <= item;
        do
            @(posedge clk);
        while (!(tick_bus.valid && tick_bus.ready));
        sb.note_tick(item, taken);
    endtask

    task automatic run_command(input tick_item_t item);
        bit taken;
        do
            offer_tick(item, taken);
        while (!taken);
    endtask

    task automatic drain_results();
        @(negedge clk);
        tick_bus.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        tick_item_t d;
        tick_item_t item;
        tick_item_t queued;
        bit         taken;
        bit         was_busy;
        int         counted;
        int         phase_end;

        rst_n = 1'b0;
        tick_bus.valid = 1'b0;
        tick_bus.data = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // idle tick with every operand bit set, nothing may be latched
        d = '1;
        d.command = CMD_NONE;
        offer_tick(d, taken);

        d = '0;
        d.command = CMD_ENGRAVER;
        d.delay_ticks = 32'd5;
        run_command(d);

        for (int code = CMD_DELAY + 1; code <= CMD_MAX; code++)
        begin
            d = '0;
            d.command = 3'(code);
            run_command(d);
        end

        // motor move without any steps
        d = '0;
        d.command = CMD_MOTOR;
        d.rate_a = '1;
        d.rate_b = '1;
        d.rate_c = '1;
        d.direction = 3'b111;
        run_command(d);

        d = '0;
        d.command = CMD_DELAY;
        run_command(d);
        d.delay_ticks = 32'hFFFF_FFFF;
        run_command(d);
        d.command = CMD_SERVO;
        d.delay_ticks = DELAY_MAX_TICKS + 1;
        run_command(d);
        d.delay_ticks = 32'd2;
        run_command(d);

        d = '0;
        d.command = CMD_MOTOR;
        d.steps_a = 32'd1;
        d.steps_b = 32'd1;
        d.steps_c = 32'd1;
        d.rate_a = 32'h8000_0000;
        d.rate_b = 32'h8000_0000;
        d.rate_c = 32'h8000_0000;
        d.accel_a = 32'sh7FFF_FFFF;
        d.accel_b = 32'sh8000_0000;
        d.direction = 3'b101;
        run_command(d);

        // rate starting at zero and ramping up, falling rate on axis three
        d = '0;
        d.command = CMD_MOTOR;
        d.steps_a = 32'd3;
        d.steps_c = 32'd2;
        d.rate_b = 32'hFFFF_FFFF;
        d.accel_a = 32'sh4000_0000;
        d.rate_c = 32'h6000_0000;
        d.accel_c = -32'sd1;
        d.direction = 3'b010;
        run_command(d);

        queued = random_command();
        counted = 0;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    src_idle_pct = 0;
                    sink_stall_pct = 0;
                    hold_req++;
                end
                1:
                begin
                    src_idle_pct = 50;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    drain_results();
                    src_idle_pct = 0;
                    sink_stall_pct = 50;
                end
                default:
                begin
                    src_idle_pct = 22;
                    sink_stall_pct = 22;
                end
            endcase
            phase_end = (phase + 1) * RANDOM_TICKS / 4;
            while (counted < phase_end)
            begin
                was_busy = sb.busy();
                if (was_busy)
                    item = ($urandom_range(0, 1) == 0) ? random_fields() : queued;
                else if ($urandom_range(0, 9) == 0)
                begin
                    item = random_fields();
                    item.command = CMD_NONE;
                end
                else
                    item = queued;
                offer_tick(item, taken);
                if (taken)
                    queued = random_command();
                if (was_busy || taken)
                    counted++;
            end
        end

        // long move with full step counts, left running to the end
        d = '0;
        d.command = CMD_MOTOR;
        d.steps_a = '1;
        d.steps_b = '1;
        d.steps_c = '1;
        d.rate_a = 32'h8000_0000;
        d.rate_b = 32'hC000_0000;
        d.rate_c = 32'h4000_0000;
        d.direction = 3'b110;
        run_command(d);
        for (int n = 0; n < TAIL_TICKS; n++)
            offer_tick(random_fields(), taken);

        drain_results();
        repeat (4) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule
